// ===== design/anl_pkg.sv =====
package anl_pkg;

    localparam int unsigned MAX_FRAME_BYTES = 2048;
    localparam int unsigned POS_W = 12;
    localparam int unsigned END_W = POS_W + 1;

    localparam logic [POS_W-1:0] OPT_BASE = POS_W'(78);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME_BYTES);

    localparam logic [15:0] ETH_TYPE_ARP = 16'h0806;
    localparam logic [15:0] ETH_TYPE_IPV6 = 16'h86DD;
    localparam logic [15:0] ARP_PTYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ARP_HTYPE_ETH = 16'h0001;
    localparam logic [7:0] ARP_HLEN = 8'd6;
    localparam logic [7:0] ARP_PLEN = 8'd4;
    localparam logic [7:0] NEXT_HDR_ICMPV6 = 8'd58;
    localparam logic [7:0] ICMPV6_NS = 8'd135;
    localparam logic [7:0] ICMPV6_NA = 8'd136;
    localparam logic [7:0] OPT_SRC_LL = 8'd1;
    localparam logic [7:0] OPT_TGT_LL = 8'd2;

    localparam logic [1:0] LEARN_NONE = 2'd0;
    localparam logic [1:0] LEARN_ARP = 2'd1;
    localparam logic [1:0] LEARN_NS = 2'd2;
    localparam logic [1:0] LEARN_NA = 2'd3;

endpackage

// ===== design/anl_in_if.sv =====
interface anl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;

    modport source (output valid, output frame_byte, output last_byte, input ready);
    modport sink (input valid, input frame_byte, input last_byte, output ready);
endinterface

// ===== design/anl_out_if.sv =====
interface anl_out_if;
    logic        valid;
    logic        ready;
    logic        consumed;
    logic [1:0]  learn_kind;
    logic [63:0] ip_high;
    logic [63:0] ip_low;
    logic [47:0] mac_address;
    logic        too_long;

    modport source (output valid, output consumed, output learn_kind, output ip_high,
                    output ip_low, output mac_address, output too_long, input ready);
    modport sink (input valid, input consumed, input learn_kind, input ip_high,
                  input ip_low, input mac_address, input too_long, output ready);
endinterface

// ===== design/arp_ndp_neighbor_learn_parser_core.sv =====
// Frame bytes enter one beat per cycle on i_frame and are parsed on the fly. For the beat
// that carries last_byte, the block raises o_result.valid at the clock edge at which that beat
// leaves the input register; the beat is held there while an earlier result is still waiting
// on o_result. The block sustains one byte per clock: the input register is held back only
// while a finished result waits on o_result and the next byte in line is itself the last
// byte of a frame. ARP frames are always consumed and teach an IPv4 binding when the
// header is Ethernet/IPv4 and the ARP packet is complete; IPv6 neighbor solicitations and
// advertisements are consumed and teach an IPv6 binding from the first fitting
// link-layer option. Frames longer than the maximum frame length report too_long.
module arp_ndp_neighbor_learn_parser_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    anl_in_if.sink     i_frame,
    anl_out_if.source  o_result
);

    logic                         r_in_valid;
    logic [7:0]                   r_in_byte;
    logic                         r_in_last;
    logic                         advance;

    logic [anl_pkg::POS_W-1:0]    r_pos, n_pos;
    logic [15:0]                  r_ek, n_ek;
    logic                         r_hdr_ok, n_hdr_ok;
    logic [7:0]                   r_icmp, n_icmp;
    logic [anl_pkg::POS_W-1:0]    r_nos, n_nos;
    logic [anl_pkg::POS_W-1:0]    r_opt_start, n_opt_start;
    logic [7:0]                   r_opt_kind, n_opt_kind;
    logic                         r_stop, n_stop;
    logic [1:0]                   r_pending, n_pending;
    logic [63:0]                  r_src_hi, n_src_hi;
    logic [63:0]                  r_src_lo, n_src_lo;
    logic [63:0]                  r_tgt_hi, n_tgt_hi;
    logic [63:0]                  r_tgt_lo, n_tgt_lo;
    logic [47:0]                  r_mac, n_mac;

    logic                         r_out_valid;
    logic                         r_consumed;
    logic [1:0]                   r_kind;
    logic [63:0]                  r_ip_high;
    logic [63:0]                  r_ip_low;
    logic [47:0]                  r_mac_out;
    logic                         r_too_long;

    logic                         over;
    logic [anl_pkg::END_W-1:0]    pos_x;
    logic [anl_pkg::END_W-1:0]    len;
    logic [anl_pkg::END_W-1:0]    opt_end;
    logic [7:0]                   span;
    logic                         is_arp;
    logic                         is_ndp;
    logic                         res_consumed;
    logic [1:0]                   res_kind;
    logic [63:0]                  res_hi;
    logic [63:0]                  res_lo;
    logic [47:0]                  res_mac;

    assign advance = r_in_valid && (!r_in_last || !r_out_valid || o_result.ready);
    assign i_frame.ready = !r_in_valid || advance;

    assign over  = r_pos >= anl_pkg::POS_MAX;
    assign pos_x = {1'b0, r_pos};
    assign len   = pos_x + anl_pkg::END_W'(1);
    assign span  = {r_in_byte[4:0], 3'b000};
    assign opt_end = {1'b0, r_nos} + {{(anl_pkg::END_W-8){1'b0}}, span};

    always_comb begin
        n_pos = r_pos;
        n_ek = r_ek;
        n_hdr_ok = r_hdr_ok;
        n_icmp = r_icmp;
        n_nos = r_nos;
        n_opt_start = r_opt_start;
        n_opt_kind = r_opt_kind;
        n_stop = r_stop;
        n_pending = r_pending;
        n_src_hi = r_src_hi;
        n_src_lo = r_src_lo;
        n_tgt_hi = r_tgt_hi;
        n_tgt_lo = r_tgt_lo;
        n_mac = r_mac;
        if (!over) begin
            n_pos = r_pos + anl_pkg::POS_W'(1);
            if (r_pos == anl_pkg::POS_W'(12) || r_pos == anl_pkg::POS_W'(13)) begin
                n_ek = {r_ek[7:0], r_in_byte};
            end
            if (r_pos == anl_pkg::POS_W'(13)) begin
                n_hdr_ok = 1'b1;
            end
            if (r_pos >= anl_pkg::POS_W'(14) && r_ek == anl_pkg::ETH_TYPE_ARP) begin
                if ((r_pos == anl_pkg::POS_W'(14) && r_in_byte != anl_pkg::ARP_HTYPE_ETH[15:8]) ||
                    (r_pos == anl_pkg::POS_W'(15) && r_in_byte != anl_pkg::ARP_HTYPE_ETH[7:0]) ||
                    (r_pos == anl_pkg::POS_W'(16) && r_in_byte != anl_pkg::ARP_PTYPE_IPV4[15:8]) ||
                    (r_pos == anl_pkg::POS_W'(17) && r_in_byte != anl_pkg::ARP_PTYPE_IPV4[7:0]) ||
                    (r_pos == anl_pkg::POS_W'(18) && r_in_byte != anl_pkg::ARP_HLEN) ||
                    (r_pos == anl_pkg::POS_W'(19) && r_in_byte != anl_pkg::ARP_PLEN)) begin
                    n_hdr_ok = 1'b0;
                end
                if (r_pos >= anl_pkg::POS_W'(22) && r_pos <= anl_pkg::POS_W'(27)) begin
                    n_mac = {r_mac[39:0], r_in_byte};
                end
                if (r_pos >= anl_pkg::POS_W'(28) && r_pos <= anl_pkg::POS_W'(31)) begin
                    n_src_lo = {32'd0, r_src_lo[23:0], r_in_byte};
                end
            end else if (r_pos >= anl_pkg::POS_W'(14) && r_ek == anl_pkg::ETH_TYPE_IPV6) begin
                if (r_pos == anl_pkg::POS_W'(20) && r_in_byte != anl_pkg::NEXT_HDR_ICMPV6) begin
                    n_hdr_ok = 1'b0;
                end
                if (r_pos >= anl_pkg::POS_W'(22) && r_pos <= anl_pkg::POS_W'(29)) begin
                    n_src_hi = {r_src_hi[55:0], r_in_byte};
                end
                if (r_pos >= anl_pkg::POS_W'(30) && r_pos <= anl_pkg::POS_W'(37)) begin
                    n_src_lo = {r_src_lo[55:0], r_in_byte};
                end
                if (r_pos == anl_pkg::POS_W'(54)) begin
                    n_icmp = r_in_byte;
                end
                if (r_pos >= anl_pkg::POS_W'(62) && r_pos <= anl_pkg::POS_W'(69)) begin
                    n_tgt_hi = {r_tgt_hi[55:0], r_in_byte};
                end
                if (r_pos >= anl_pkg::POS_W'(70) && r_pos <= anl_pkg::POS_W'(77)) begin
                    n_tgt_lo = {r_tgt_lo[55:0], r_in_byte};
                end
            end
            if (!r_stop) begin
                if (r_pos == r_nos) begin
                    n_opt_kind = r_in_byte;
                end else if (pos_x == {1'b0, r_nos} + anl_pkg::END_W'(1)) begin
                    if (span == 8'd0 || opt_end > anl_pkg::END_W'(anl_pkg::MAX_FRAME_BYTES)) begin
                        n_stop = 1'b1;
                    end else begin
                        if (r_icmp == anl_pkg::ICMPV6_NS && r_opt_kind == anl_pkg::OPT_SRC_LL) begin
                            n_pending = anl_pkg::LEARN_NS;
                            n_stop = 1'b1;
                        end else if (r_icmp == anl_pkg::ICMPV6_NA &&
                                     r_opt_kind == anl_pkg::OPT_TGT_LL) begin
                            n_pending = anl_pkg::LEARN_NA;
                            n_stop = 1'b1;
                        end
                        n_opt_start = r_nos;
                        n_nos = opt_end[anl_pkg::POS_W-1:0];
                    end
                end
            end else if (r_pending != anl_pkg::LEARN_NONE) begin
                if (pos_x >= {1'b0, r_opt_start} + anl_pkg::END_W'(2) &&
                    pos_x <= {1'b0, r_opt_start} + anl_pkg::END_W'(7)) begin
                    n_mac = {r_mac[39:0], r_in_byte};
                end
            end
        end
    end

    always_comb begin
        is_arp = (over || len >= anl_pkg::END_W'(14)) && n_ek == anl_pkg::ETH_TYPE_ARP;
        is_ndp = (over || len >= anl_pkg::END_W'(78)) && n_ek == anl_pkg::ETH_TYPE_IPV6 &&
                 n_hdr_ok && (n_icmp == anl_pkg::ICMPV6_NS || n_icmp == anl_pkg::ICMPV6_NA);
        res_consumed = is_arp || is_ndp;
        res_kind = anl_pkg::LEARN_NONE;
        res_hi = 64'd0;
        res_lo = 64'd0;
        res_mac = 48'd0;
        if (!over) begin
            if (is_arp && len >= anl_pkg::END_W'(42) && n_hdr_ok) begin
                res_kind = anl_pkg::LEARN_ARP;
                res_lo = n_src_lo;
                res_mac = n_mac;
            end else if (is_ndp && n_pending != anl_pkg::LEARN_NONE && len >= {1'b0, n_nos}) begin
                res_kind = n_pending;
                res_hi = (n_pending == anl_pkg::LEARN_NS) ? n_src_hi : n_tgt_hi;
                res_lo = (n_pending == anl_pkg::LEARN_NS) ? n_src_lo : n_tgt_lo;
                res_mac = n_mac;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos <= '0;
            r_ek <= '0;
            r_hdr_ok <= 1'b0;
            r_icmp <= '0;
            r_nos <= anl_pkg::OPT_BASE;
            r_opt_start <= '0;
            r_opt_kind <= '0;
            r_stop <= 1'b0;
            r_pending <= anl_pkg::LEARN_NONE;
        end else begin
            if (i_frame.ready) begin
                r_in_valid <= i_frame.valid;
            end
            if (advance && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            if (advance) begin
                if (r_in_last) begin
                    r_pos <= '0;
                    r_ek <= '0;
                    r_hdr_ok <= 1'b0;
                    r_icmp <= '0;
                    r_nos <= anl_pkg::OPT_BASE;
                    r_opt_start <= '0;
                    r_opt_kind <= '0;
                    r_stop <= 1'b0;
                    r_pending <= anl_pkg::LEARN_NONE;
                end else begin
                    r_pos <= n_pos;
                    r_ek <= n_ek;
                    r_hdr_ok <= n_hdr_ok;
                    r_icmp <= n_icmp;
                    r_nos <= n_nos;
                    r_opt_start <= n_opt_start;
                    r_opt_kind <= n_opt_kind;
                    r_stop <= n_stop;
                    r_pending <= n_pending;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_frame.ready && i_frame.valid) begin
            r_in_byte <= i_frame.frame_byte;
            r_in_last <= i_frame.last_byte;
        end
        if (advance) begin
            r_src_hi <= n_src_hi;
            r_src_lo <= n_src_lo;
            r_tgt_hi <= n_tgt_hi;
            r_tgt_lo <= n_tgt_lo;
            r_mac <= n_mac;
            if (r_in_last) begin
                r_consumed <= res_consumed;
                r_kind <= res_kind;
                r_ip_high <= res_hi;
                r_ip_low <= res_lo;
                r_mac_out <= res_mac;
                r_too_long <= over;
            end
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.consumed = r_consumed;
    assign o_result.learn_kind = r_kind;
    assign o_result.ip_high = r_ip_high;
    assign o_result.ip_low = r_ip_low;
    assign o_result.mac_address = r_mac_out;
    assign o_result.too_long = r_too_long;

    a_learn_means_consumed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.learn_kind != anl_pkg::LEARN_NONE
        |-> o_result.consumed && !o_result.too_long)
        else $error("A learned binding was reported on a frame not consumed or too long.");

    a_arp_ipv4_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.learn_kind == anl_pkg::LEARN_ARP
        |-> o_result.ip_high == 64'd0 && o_result.ip_low[63:32] == 32'd0)
        else $error("An ARP binding carried address bits above the IPv4 range.");

    a_pos_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= anl_pkg::POS_MAX)
        else $error("The byte position ran past the maximum frame length.");

    a_pending_stops_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending != anl_pkg::LEARN_NONE |-> r_stop)
        else $error("A binding is pending while the option walk is still running.");

    a_frame_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_last |=> r_pos == '0 && r_out_valid)
        else $error("The parse state was not cleared at the end of a frame.");

endmodule

// ===== tb/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam logic [7:0] ICMPV6_RA = 8'd134;

    typedef struct packed {
        logic [7:0] data;
        logic       is_last;
    } t_frame_beat;

    typedef struct packed {
        logic        consumed;
        logic [1:0]  learn_kind;
        logic [63:0] ip_high;
        logic [63:0] ip_low;
        logic [47:0] mac_address;
        logic        too_long;
    } t_neighbor_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    anl_in_if frame_bus();
    anl_out_if result_bus();

    arp_ndp_neighbor_learn_parser_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_frame  (frame_bus),
        .o_result (result_bus)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_frame_beat      pending_beats[$];
    t_neighbor_result expected_bindings[$];
    logic [7:0]       frame_buf[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_requests = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    int unsigned idle_cycles = 0;
    logic        watchdog_expired = 1'b0;
    int unsigned error_count = 0;
    int unsigned frames_sent = 0;
    int unsigned bytes_sent = 0;
    int unsigned kind_seen[4] = '{0, 0, 0, 0};
    int unsigned oversize_seen = 0;

    logic [11:0] parse_pos;
    logic [15:0] parse_ether_kind;
    logic        parse_hdr_ok;
    logic [7:0]  parse_icmp_type;
    logic [11:0] parse_opt_next;
    logic [7:0]  parse_opt_kind;
    logic [7:0]  parse_opt_span;
    logic        parse_walk_done;
    logic [63:0] parse_src_addr[2];
    logic [63:0] parse_tgt_addr[2];
    logic [47:0] parse_hw_addr;
    logic [1:0]  parse_binding;

    task automatic clear_parse();
        parse_pos = '0;
        parse_ether_kind = '0;
        parse_hdr_ok = 1'b0;
        parse_icmp_type = '0;
        parse_opt_next = anl_pkg::OPT_BASE;
        parse_opt_kind = '0;
        parse_opt_span = '0;
        parse_walk_done = 1'b0;
        parse_src_addr = '{64'd0, 64'd0};
        parse_tgt_addr = '{64'd0, 64'd0};
        parse_hw_addr = '0;
        parse_binding = anl_pkg::LEARN_NONE;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic is_last);
        logic [11:0]      p;
        logic             over;
        logic [12:0]      frame_len;
        logic [12:0]      opt_end;
        logic [12:0]      opt_start;
        logic [7:0]       span;
        logic             arp_frame;
        logic             ndp_frame;
        t_neighbor_result res;
        p = parse_pos;
        over = (p >= anl_pkg::POS_MAX);
        if (!over) begin
            if (p == 12'd12 || p == 12'd13) begin
                parse_ether_kind = {parse_ether_kind[7:0], b};
            end
            if (p == 12'd13) begin
                parse_hdr_ok = 1'b1;
            end
            if (p >= 12'd14 && parse_ether_kind == anl_pkg::ETH_TYPE_ARP) begin
                if ((p == 12'd14 && b != anl_pkg::ARP_HTYPE_ETH[15:8]) ||
                    (p == 12'd15 && b != anl_pkg::ARP_HTYPE_ETH[7:0]) ||
                    (p == 12'd16 && b != anl_pkg::ARP_PTYPE_IPV4[15:8]) ||
                    (p == 12'd17 && b != anl_pkg::ARP_PTYPE_IPV4[7:0]) ||
                    (p == 12'd18 && b != anl_pkg::ARP_HLEN) ||
                    (p == 12'd19 && b != anl_pkg::ARP_PLEN)) begin
                    parse_hdr_ok = 1'b0;
                end
                if (p >= 12'd22 && p <= 12'd27) begin
                    parse_hw_addr = {parse_hw_addr[39:0], b};
                end
                if (p >= 12'd28 && p <= 12'd31) begin
                    parse_src_addr[1] = {32'd0, parse_src_addr[1][23:0], b};
                end
            end else if (p >= 12'd14 && parse_ether_kind == anl_pkg::ETH_TYPE_IPV6) begin
                if (p == 12'd20 && b != anl_pkg::NEXT_HDR_ICMPV6) begin
                    parse_hdr_ok = 1'b0;
                end
                if (p >= 12'd22 && p <= 12'd29) begin
                    parse_src_addr[0] = {parse_src_addr[0][55:0], b};
                end
                if (p >= 12'd30 && p <= 12'd37) begin
                    parse_src_addr[1] = {parse_src_addr[1][55:0], b};
                end
                if (p == 12'd54) begin
                    parse_icmp_type = b;
                end
                if (p >= 12'd62 && p <= 12'd69) begin
                    parse_tgt_addr[0] = {parse_tgt_addr[0][55:0], b};
                end
                if (p >= 12'd70 && p <= 12'd77) begin
                    parse_tgt_addr[1] = {parse_tgt_addr[1][55:0], b};
                end
            end
            if (!parse_walk_done) begin
                if (p == parse_opt_next) begin
                    parse_opt_kind = b;
                end else if ({1'b0, p} == {1'b0, parse_opt_next} + 13'd1) begin
                    span = {b[4:0], 3'b000};
                    opt_end = {1'b0, parse_opt_next} + {5'd0, span};
                    parse_opt_span = span;
                    if (span == 8'd0 || opt_end > 13'(anl_pkg::MAX_FRAME_BYTES)) begin
                        parse_walk_done = 1'b1;
                    end else begin
                        if (parse_icmp_type == anl_pkg::ICMPV6_NS &&
                            parse_opt_kind == anl_pkg::OPT_SRC_LL) begin
                            parse_binding = anl_pkg::LEARN_NS;
                        end else if (parse_icmp_type == anl_pkg::ICMPV6_NA &&
                                     parse_opt_kind == anl_pkg::OPT_TGT_LL) begin
                            parse_binding = anl_pkg::LEARN_NA;
                        end
                        if (parse_binding != anl_pkg::LEARN_NONE) begin
                            parse_walk_done = 1'b1;
                        end
                        parse_opt_next = opt_end[11:0];
                    end
                end
            end else if (parse_binding != anl_pkg::LEARN_NONE) begin
                opt_start = {1'b0, parse_opt_next} - {5'd0, parse_opt_span};
                if ({1'b0, p} >= opt_start + 13'd2 && {1'b0, p} <= opt_start + 13'd7) begin
                    parse_hw_addr = {parse_hw_addr[39:0], b};
                end
            end
            parse_pos = p + 12'd1;
        end
        if (is_last) begin
            frame_len = {1'b0, p} + 13'd1;
            arp_frame = (over || frame_len >= 13'd14) &&
                        parse_ether_kind == anl_pkg::ETH_TYPE_ARP;
            ndp_frame = (over || frame_len >= {1'b0, anl_pkg::OPT_BASE}) &&
                        parse_ether_kind == anl_pkg::ETH_TYPE_IPV6 && parse_hdr_ok &&
                        (parse_icmp_type == anl_pkg::ICMPV6_NS ||
                         parse_icmp_type == anl_pkg::ICMPV6_NA);
            res = '0;
            res.consumed = arp_frame || ndp_frame;
            res.too_long = over;
            if (!over) begin
                if (arp_frame && frame_len >= 13'd42 && parse_hdr_ok) begin
                    res.learn_kind = anl_pkg::LEARN_ARP;
                    res.ip_low = parse_src_addr[1];
                    res.mac_address = parse_hw_addr;
                end else if (ndp_frame && parse_binding != anl_pkg::LEARN_NONE &&
                             frame_len >= {1'b0, parse_opt_next}) begin
                    res.learn_kind = parse_binding;
                    if (parse_binding == anl_pkg::LEARN_NS) begin
                        res.ip_high = parse_src_addr[0];
                        res.ip_low = parse_src_addr[1];
                    end else begin
                        res.ip_high = parse_tgt_addr[0];
                        res.ip_low = parse_tgt_addr[1];
                    end
                    res.mac_address = parse_hw_addr;
                end
            end
            expected_bindings.push_back(res);
            clear_parse();
        end
    endtask

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            error_count++;
        end
    endfunction

    task automatic start_frame(input logic [15:0] ether_kind);
        frame_buf.delete();
        repeat (12) frame_buf.push_back(8'($urandom));
        frame_buf.push_back(ether_kind[15:8]);
        frame_buf.push_back(ether_kind[7:0]);
    endtask

    task automatic pad_frame(input int unsigned count);
        repeat (count) frame_buf.push_back(8'($urandom));
    endtask

    task automatic cut_frame(input int unsigned len);
        while (frame_buf.size() > len) void'(frame_buf.pop_back());
    endtask

    task automatic build_arp(input logic good);
        int unsigned idx;
        start_frame(anl_pkg::ETH_TYPE_ARP);
        frame_buf.push_back(anl_pkg::ARP_HTYPE_ETH[15:8]);
        frame_buf.push_back(anl_pkg::ARP_HTYPE_ETH[7:0]);
        frame_buf.push_back(anl_pkg::ARP_PTYPE_IPV4[15:8]);
        frame_buf.push_back(anl_pkg::ARP_PTYPE_IPV4[7:0]);
        frame_buf.push_back(anl_pkg::ARP_HLEN);
        frame_buf.push_back(anl_pkg::ARP_PLEN);
        pad_frame(22);
        if (!good) begin
            idx = 14 + $urandom_range(5);
            frame_buf[idx] = frame_buf[idx] ^ 8'($urandom_range(1, 255));
        end
    endtask

    task automatic build_ndp(input logic [7:0] msg_type, input logic [7:0] next_hdr);
        int unsigned pos;
        start_frame(anl_pkg::ETH_TYPE_IPV6);
        for (pos = 14; pos < 78; pos++) begin
            if (pos == 20) begin
                frame_buf.push_back(next_hdr);
            end else if (pos == 54) begin
                frame_buf.push_back(msg_type);
            end else begin
                frame_buf.push_back(8'($urandom));
            end
        end
    endtask

    task automatic add_option(input logic [7:0] kind, input logic [7:0] len_code);
        int unsigned span;
        span = 32'({len_code[4:0], 3'b000});
        frame_buf.push_back(kind);
        frame_buf.push_back(len_code);
        if (span >= 2) begin
            pad_frame(span - 2);
        end
    endtask

    task automatic send_frame();
        foreach (frame_buf[i]) begin
            pending_beats.push_back('{data: frame_buf[i], is_last: (i == frame_buf.size() - 1)});
        end
        frames_sent++;
        bytes_sent += frame_buf.size();
    endtask

    task automatic wait_drain();
        while (pending_beats.size() != 0 || frame_bus.valid || expected_bindings.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic send_random_frames(input int unsigned count);
        int unsigned pick;
        logic [7:0]  msg;
        repeat (count) begin
            pick = $urandom_range(99);
            msg = pick[0] ? anl_pkg::ICMPV6_NS : anl_pkg::ICMPV6_NA;
            if (pick < 35) begin
                build_ndp(msg, anl_pkg::NEXT_HDR_ICMPV6);
                repeat ($urandom_range(2)) begin
                    add_option(8'($urandom_range(1, 4)), 8'($urandom_range(1, 2)));
                end
                add_option(msg == anl_pkg::ICMPV6_NS ? anl_pkg::OPT_SRC_LL : anl_pkg::OPT_TGT_LL,
                           8'($urandom_range(1, 3)));
                if ($urandom_range(3) == 0) begin
                    pad_frame($urandom_range(1, 16));
                end else if ($urandom_range(5) == 0) begin
                    cut_frame(frame_buf.size() - $urandom_range(1, 8));
                end
            end else if (pick < 60) begin
                build_arp($urandom_range(4) != 0);
                if ($urandom_range(5) == 0) begin
                    cut_frame($urandom_range(14, 41));
                end else begin
                    pad_frame($urandom_range(0, 22));
                end
            end else if (pick < 70) begin
                case ($urandom_range(3))
                    0: msg = ICMPV6_RA;
                    1: msg = anl_pkg::ICMPV6_NS;
                    2: msg = anl_pkg::ICMPV6_NA;
                    default: msg = 8'($urandom);
                endcase
                build_ndp(msg, $urandom_range(1) ? anl_pkg::NEXT_HDR_ICMPV6 : 8'($urandom));
                repeat ($urandom_range(1, 3)) add_option(8'($urandom_range(0, 3)), 8'($urandom));
                cut_frame($urandom_range(60, frame_buf.size()));
            end else if (pick < 80) begin
                frame_buf.delete();
                pad_frame($urandom_range(1, 13));
            end else begin
                start_frame($urandom_range(1) ? 16'($urandom) : anl_pkg::ARP_PTYPE_IPV4);
                pad_frame($urandom_range(0, 70));
            end
            send_frame();
        end
    endtask

    always @(posedge i_clk) begin : drive_frame
        t_frame_beat beat;
        if (!i_rst_n) begin
            frame_bus.valid <= 1'b0;
        end else if (!frame_bus.valid || frame_bus.ready) begin
            if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                beat = pending_beats.pop_front();
                frame_bus.valid <= 1'b1;
                frame_bus.frame_byte <= beat.data;
                frame_bus.last_byte <= beat.is_last;
            end else begin
                frame_bus.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && frame_bus.valid && frame_bus.ready) begin
            parse_byte(frame_bus.frame_byte, frame_bus.last_byte);
        end
    end

    always @(posedge i_clk) begin
        if (hold_seen != hold_requests) begin
            hold_seen <= hold_requests;
            hold_left <= HOLD_CYCLES;
            result_bus.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            result_bus.ready <= 1'b0;
        end else begin
            result_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : check_result
        t_neighbor_result want;
        if (i_rst_n && result_bus.valid && result_bus.ready) begin
            if (expected_bindings.size() == 0) begin
                $error("result beat arrived with no frame outstanding");
                error_count++;
            end else begin
                want = expected_bindings.pop_front();
                check_field("consumed", 64'(want.consumed), 64'(result_bus.consumed));
                check_field("learn_kind", 64'(want.learn_kind), 64'(result_bus.learn_kind));
                check_field("ip_high", want.ip_high, result_bus.ip_high);
                check_field("ip_low", want.ip_low, result_bus.ip_low);
                check_field("mac_address", 64'(want.mac_address), 64'(result_bus.mac_address));
                check_field("too_long", 64'(want.too_long), 64'(result_bus.too_long));
                kind_seen[result_bus.learn_kind]++;
                if (result_bus.too_long) begin
                    oversize_seen++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (frame_bus.valid && frame_bus.ready) ||
            (result_bus.valid && result_bus.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            watchdog_expired <= 1'b1;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (watchdog_expired);
        $error("no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int unsigned k;
        i_rst_n = 1'b0;
        frame_bus.valid = 1'b0;
        frame_bus.frame_byte = '0;
        frame_bus.last_byte = 1'b0;
        result_bus.ready = 1'b0;
        clear_parse();
        send_idle_pct = 8;
        recv_idle_pct = 58;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        frame_buf.delete();
        frame_buf.push_back(8'hFF);
        send_frame();
        start_frame(anl_pkg::ETH_TYPE_IPV6);
        cut_frame(13);
        send_frame();
        start_frame(anl_pkg::ETH_TYPE_ARP);
        send_frame();
        build_arp(1'b1);
        cut_frame(41);
        send_frame();
        build_arp(1'b1);
        for (k = 22; k < 32; k++) frame_buf[k] = 8'hFF;
        send_frame();
        build_arp(1'b1);
        frame_buf[18] = 8'd8;
        send_frame();
        build_ndp(anl_pkg::ICMPV6_NS, anl_pkg::NEXT_HDR_ICMPV6);
        add_option(anl_pkg::OPT_SRC_LL, 8'd1);
        send_frame();
        build_ndp(anl_pkg::ICMPV6_NA, anl_pkg::NEXT_HDR_ICMPV6);
        add_option(anl_pkg::OPT_SRC_LL, 8'd1);
        add_option(anl_pkg::OPT_TGT_LL, 8'd1);
        send_frame();
        // The length byte wraps to a zero span, which ends the option walk.
        build_ndp(anl_pkg::ICMPV6_NS, anl_pkg::NEXT_HDR_ICMPV6);
        add_option(anl_pkg::OPT_SRC_LL, 8'd32);
        send_frame();
        wait_drain();

        send_idle_pct = 58;
        recv_idle_pct = 8;
        send_random_frames(3);
        wait_drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        // Short frames while the result side is held off, so the input has to back up.
        hold_requests++;
        repeat (12) begin
            frame_buf.delete();
            pad_frame($urandom_range(1, 2));
            send_frame();
        end
        wait_drain();
        send_random_frames(1);

        wait_drain();
        repeat (20) @(posedge i_clk);
        if (expected_bindings.size() != 0) begin
            $error("%0d results never arrived", expected_bindings.size());
            error_count++;
        end
        $display("Sent %0d frames, %0d bytes, through idle, stalled and back-to-back phases.",
                 frames_sent, bytes_sent);
        $display("Results: %0d without binding, %0d ARP, %0d NS, %0d NA, %0d oversize.",
                 kind_seen[anl_pkg::LEARN_NONE], kind_seen[anl_pkg::LEARN_ARP],
                 kind_seen[anl_pkg::LEARN_NS], kind_seen[anl_pkg::LEARN_NA], oversize_seen);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/anl_pkg.sv
design/anl_in_if.sv
design/anl_out_if.sv
design/arp_ndp_neighbor_learn_parser_core.sv
tb/tb.sv
